@@ src/b32e_pkg.sv @@
`timescale 1ns / 1ps
package b32e_pkg;

    localparam logic [1:0] OP_PART   = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_RANGE = 3'd1;
    localparam logic [2:0] ERR_UPPER = 3'd2;
    localparam logic [2:0] ERR_LONG  = 3'd3;
    localparam logic [2:0] ERR_DATA  = 3'd4;

    localparam logic [29:0] CONST_BECH32  = 30'h0000_0001;
    localparam logic [29:0] CONST_BECH32M = 30'h2bc8_30a3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] value;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD_ZERO,
        ST_FOLD_PART,
        ST_SEP,
        ST_DATA,
        ST_CSUM_FOLD,
        ST_CSUM_OUT
    } back_state_t;

    function automatic logic [29:0] poly_step(input logic [29:0] c);
        logic [29:0] r;
        logic [4:0]  top;
        begin
            top = c[29:25];
            r = {c[24:0], 5'd0};
            if (top[0]) r = r ^ 30'h3b6a57b2;
            if (top[1]) r = r ^ 30'h26508e6d;
            if (top[2]) r = r ^ 30'h1ea119fa;
            if (top[3]) r = r ^ 30'h3d4233dd;
            if (top[4]) r = r ^ 30'h2a1462b3;
            return r;
        end
    endfunction

    function automatic logic [6:0] letter(input logic [4:0] s);
        logic [6:0] ch;
        begin
            case (s)
                5'd0:  ch = 7'h71; 5'd1:  ch = 7'h70; 5'd2:  ch = 7'h7a; 5'd3:  ch = 7'h72;
                5'd4:  ch = 7'h79; 5'd5:  ch = 7'h39; 5'd6:  ch = 7'h78; 5'd7:  ch = 7'h38;
                5'd8:  ch = 7'h67; 5'd9:  ch = 7'h66; 5'd10: ch = 7'h32; 5'd11: ch = 7'h74;
                5'd12: ch = 7'h76; 5'd13: ch = 7'h64; 5'd14: ch = 7'h77; 5'd15: ch = 7'h30;
                5'd16: ch = 7'h73; 5'd17: ch = 7'h33; 5'd18: ch = 7'h6a; 5'd19: ch = 7'h6e;
                5'd20: ch = 7'h35; 5'd21: ch = 7'h34; 5'd22: ch = 7'h6b; 5'd23: ch = 7'h68;
                5'd24: ch = 7'h63; 5'd25: ch = 7'h65; 5'd26: ch = 7'h36; 5'd27: ch = 7'h6d;
                5'd28: ch = 7'h75; 5'd29: ch = 7'h61; 5'd30: ch = 7'h37; 5'd31: ch = 7'h6c;
                default: ch = 7'h71;
            endcase
            return ch;
        end
    endfunction

endpackage

@@ src/b32e_queue.sv @@
`timescale 1ns / 1ps
module b32e_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  b32e_pkg::item_t   wr_item,
    output logic              rd_valid,
    input  logic              rd_ready,
    output b32e_pkg::item_t   rd_item
);
    import b32e_pkg::*;

    item_t      slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wptr_next = do_wr ? ~wptr_reg : wptr_reg;
        rptr_next = do_rd ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) slot_reg[wptr_reg] <= wr_item;
    end
endmodule

@@ src/b32e_back.sv @@
`timescale 1ns / 1ps
module b32e_back #(
    parameter int MAX_STRING_LEN = 90,
    parameter int PART_DEPTH     = 83
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              variant,
    input  logic              q_valid,
    output logic              q_ready,
    input  b32e_pkg::item_t   q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [6:0]        m_out_char,
    output logic              m_end_of_string,
    output logic [2:0]        m_error_code,
    output logic              busy
);
    import b32e_pkg::*;

    localparam int AW = (PART_DEPTH > 1) ? $clog2(PART_DEPTH) : 1;
    localparam int CW = 7;

    back_state_t state_reg, state_next;

    logic [4:0]    mem [PART_DEPTH];
    logic [4:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic [29:0]   chk_reg, chk_next;
    logic [CW-1:0] pcnt_reg, pcnt_next;
    logic [CW-1:0] tcnt_reg, tcnt_next;
    logic          in_data_reg, in_data_next;
    logic          hold_reg, hold_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          fin_reg, fin_next;
    logic [4:0]    dval_reg, dval_next;

    logic          ov_reg, ov_next;
    logic [6:0]    oc_reg, oc_next;
    logic          oe_reg, oe_next;
    logic [2:0]    ocode_reg, ocode_next;

    logic          out_free;
    logic          take;
    logic          mem_wr;
    logic [1:0]    op;
    logic [7:0]    v;

    assign out_free = !ov_reg || m_ready;
    assign op       = q_item.opcode;
    assign v        = q_item.value;
    assign rd_addr  = idx_reg[AW-1:0];
    assign m_valid  = ov_reg;
    assign m_out_char = oc_reg;
    assign m_end_of_string = oe_reg;
    assign m_error_code = ocode_reg;
    assign busy = (state_reg != ST_IDLE) || ov_reg;
    assign q_ready = (state_reg == ST_IDLE) && out_free;
    assign take = q_valid && q_ready;

    always_comb begin
        state_next = state_reg;
        if (take && !hold_reg) begin
            case (op)
                OP_DATA: begin
                    if (!in_data_reg) state_next = ST_FOLD_ZERO;
                    else state_next = ST_DATA;
                    if ({1'b0, tcnt_reg} + (in_data_reg ? 8'd7 : 8'd8) > 8'(MAX_STRING_LEN)
                        || v > 8'd31)
                        state_next = ST_IDLE;
                end
                OP_FINISH: state_next = in_data_reg ? ST_CSUM_FOLD : ST_FOLD_ZERO;
                default:   state_next = ST_IDLE;
            endcase
        end else begin
            case (state_reg)
                ST_FOLD_ZERO: state_next = (pcnt_reg == '0) ? ST_SEP : ST_FOLD_PART;
                ST_FOLD_PART: if (idx_reg == pcnt_reg) state_next = ST_SEP;
                ST_SEP:  if (out_free) state_next = fin_reg ? ST_CSUM_FOLD : ST_DATA;
                ST_DATA: if (out_free) state_next = ST_IDLE;
                ST_CSUM_FOLD: if (idx_reg == CW'(6)) state_next = ST_CSUM_OUT;
                ST_CSUM_OUT: if (out_free && idx_reg == CW'(5)) state_next = ST_IDLE;
                default: state_next = state_reg;
            endcase
        end
    end

    always_comb begin
        chk_next     = chk_reg;
        pcnt_next    = pcnt_reg;
        tcnt_next    = tcnt_reg;
        in_data_next = in_data_reg;
        hold_next    = hold_reg;
        idx_next     = idx_reg;
        fin_next     = fin_reg;
        dval_next    = dval_reg;
        ov_next      = ov_reg && !m_ready;
        oc_next      = oc_reg;
        oe_next      = oe_reg;
        ocode_next   = ocode_reg;
        mem_wr       = 1'b0;
        if (take) begin
            if (hold_reg) begin
                if (op == OP_FINISH) begin
                    chk_next = 30'd1; pcnt_next = '0; tcnt_next = '0;
                    in_data_next = 1'b0; hold_next = 1'b0;
                end
            end else begin
                case (op)
                    OP_PART: begin
                        if (!in_data_reg) begin
                            ov_next = 1'b1; oc_next = 7'd0; oe_next = 1'b1;
                            if ({1'b0, pcnt_reg} >= 8'(PART_DEPTH)
                                || {1'b0, pcnt_reg} + 8'd8 > 8'(MAX_STRING_LEN)) begin
                                ocode_next = ERR_LONG; hold_next = 1'b1;
                            end else if (v < 8'd33 || v > 8'd126) begin
                                ocode_next = ERR_RANGE; hold_next = 1'b1;
                            end else if (v >= 8'h41 && v <= 8'h5a) begin
                                ocode_next = ERR_UPPER; hold_next = 1'b1;
                            end else begin
                                chk_next = poly_step(chk_reg) ^ {27'd0, v[7:5]};
                                mem_wr = 1'b1;
                                pcnt_next = pcnt_reg + 1'b1;
                                tcnt_next = tcnt_reg + 1'b1;
                                oc_next = v[6:0]; oe_next = 1'b0; ocode_next = ERR_NONE;
                            end
                        end
                    end
                    OP_DATA: begin
                        dval_next = v[4:0]; fin_next = 1'b0; idx_next = '0;
                        if ({1'b0, tcnt_reg} + (in_data_reg ? 8'd7 : 8'd8)
                            > 8'(MAX_STRING_LEN)) begin
                            ov_next = 1'b1; oc_next = 7'd0; oe_next = 1'b1;
                            ocode_next = ERR_LONG; hold_next = 1'b1;
                        end else if (v > 8'd31) begin
                            ov_next = 1'b1; oc_next = 7'd0; oe_next = 1'b1;
                            ocode_next = ERR_DATA; hold_next = 1'b1;
                        end
                    end
                    OP_FINISH: begin
                        fin_next = 1'b1; idx_next = '0;
                    end
                    default: ;
                endcase
            end
        end else begin
            case (state_reg)
                ST_FOLD_ZERO: chk_next = poly_step(chk_reg);
                ST_FOLD_PART: begin
                    if (idx_reg != '0)
                        chk_next = poly_step(chk_reg) ^ {25'd0, rd_data_reg};
                    idx_next = idx_reg + 1'b1;
                end
                ST_SEP: if (out_free) begin
                    ov_next = 1'b1; oc_next = 7'h31; oe_next = 1'b0; ocode_next = ERR_NONE;
                    tcnt_next = tcnt_reg + 1'b1; in_data_next = 1'b1; idx_next = '0;
                end
                ST_DATA: if (out_free) begin
                    chk_next = poly_step(chk_reg) ^ {25'd0, dval_reg};
                    tcnt_next = tcnt_reg + 1'b1;
                    ov_next = 1'b1; oc_next = letter(dval_reg); oe_next = 1'b0;
                    ocode_next = ERR_NONE;
                end
                ST_CSUM_FOLD: begin
                    if (idx_reg == CW'(6)) begin
                        chk_next = chk_reg ^ (variant ? CONST_BECH32M : CONST_BECH32);
                        idx_next = '0;
                    end else begin
                        chk_next = poly_step(chk_reg);
                        idx_next = idx_reg + 1'b1;
                    end
                end
                ST_CSUM_OUT: if (out_free) begin
                    ov_next = 1'b1; oc_next = letter(chk_reg[29:25]);
                    oe_next = (idx_reg == CW'(5)); ocode_next = ERR_NONE;
                    chk_next = {chk_reg[24:0], 5'd0};
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == CW'(5)) begin
                        chk_next = 30'd1; pcnt_next = '0; tcnt_next = '0;
                        in_data_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chk_reg     <= 30'd1;
            pcnt_reg    <= '0;
            tcnt_reg    <= '0;
            in_data_reg <= 1'b0;
            hold_reg    <= 1'b0;
            idx_reg     <= '0;
            fin_reg     <= 1'b0;
            ov_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chk_reg     <= chk_next;
            pcnt_reg    <= pcnt_next;
            tcnt_reg    <= tcnt_next;
            in_data_reg <= in_data_next;
            hold_reg    <= hold_next;
            idx_reg     <= idx_next;
            fin_reg     <= fin_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        dval_reg  <= dval_next;
        oc_reg    <= oc_next;
        oe_reg    <= oe_next;
        ocode_reg <= ocode_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) mem[pcnt_reg[AW-1:0]] <= v[4:0];
        rd_data_reg <= mem[rd_addr];
    end
endmodule

@@ src/bech32_string_encoder.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake        | beat
// s_      | in        | s_valid/s_ready  | s_opcode, s_value
// m_      | out       | m_valid/m_ready  | m_out_char, m_end_of_string, m_error_code
// A part char is checked, stored and echoed; the first data or finish item first
// runs a zero fold, a fold over the stored part chars and the separator.
// Finish runs: accept, six folds, final XOR, six checksum letters.
// aresetn is synchronous, active low; no clearing pass is needed.
// A two-entry queue decouples input from back end; m_ready stalls the back end.
module bech32_string_encoder #(
    parameter int MAX_STRING_LEN = 90,
    parameter int PART_DEPTH     = 83
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_out_char,
    output logic        m_end_of_string,
    output logic [2:0]  m_error_code
);
    import b32e_pkg::*;

    logic  variant_reg, variant_next;
    logic  q_valid, q_ready, busy;
    item_t in_item, q_item;

    assign pready  = 1'b1;
    assign prdata  = (paddr == 2'd0) ? {31'd0, variant_reg} : 32'd0;
    assign in_item = '{opcode: s_opcode, value: s_value};

    always_comb begin
        variant_next = variant_reg;
        if (psel && penable && pwrite && paddr == 2'd0) variant_next = pwdata[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) variant_reg <= 1'b0;
        else          variant_reg <= variant_next;
    end

    b32e_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_item(in_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    b32e_back #(.MAX_STRING_LEN(MAX_STRING_LEN), .PART_DEPTH(PART_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .variant(variant_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_char(m_out_char),
        .m_end_of_string(m_end_of_string), .m_error_code(m_error_code),
        .busy(busy)
    );

`ifndef SYNTHESIS
    a_err_eos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_NONE |-> m_end_of_string && m_out_char == 7'd0)
        else $error("error beat malformed");
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_error_code <= ERR_DATA)
        else $error("bad error code");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy |-> !m_valid)
        else $error("result while idle");
`endif
endmodule
